@@ src/pps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, codes and helpers of the predator-prey ODE stepper.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PREY_GROWTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREDATION_RATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREDATOR_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREDATOR_DEATH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_TIME       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_RK4        = 3'd6;

   // datapath operations
   localparam logic [2:0] OP_NOP = 3'd0;  // operands still feed the multiplier
   localparam logic [2:0] OP_WB  = 3'd1;  // round and saturate product, write back
   localparam logic [2:0] OP_ADD = 3'd2;
   localparam logic [2:0] OP_SUB = 3'd3;
   localparam logic [2:0] OP_ACC = 3'd4;  // add k into the RK4 weighted sums

   // operand sources
   localparam logic [3:0] SRC_X    = 4'd0;
   localparam logic [3:0] SRC_Y    = 4'd1;
   localparam logic [3:0] SRC_PX   = 4'd2;
   localparam logic [3:0] SRC_PY   = 4'd3;
   localparam logic [3:0] SRC_KX   = 4'd4;
   localparam logic [3:0] SRC_KY   = 4'd5;
   localparam logic [3:0] SRC_T1   = 4'd6;
   localparam logic [3:0] SRC_T2   = 4'd7;
   localparam logic [3:0] SRC_A11  = 4'd8;
   localparam logic [3:0] SRC_A12  = 4'd9;
   localparam logic [3:0] SRC_A21  = 4'd10;
   localparam logic [3:0] SRC_A22  = 4'd11;
   localparam logic [3:0] SRC_INC  = 4'd12;  // h/2 in the first two stages, else h
   localparam logic [3:0] SRC_FINC = 4'd13;  // h/6 for RK4, h for Euler
   localparam logic [3:0] SRC_FINX = 4'd14;  // saturated sum for RK4, kx for Euler
   localparam logic [3:0] SRC_FINY = 4'd15;

   // destinations
   localparam logic [2:0] DST_X  = 3'd0;
   localparam logic [2:0] DST_Y  = 3'd1;
   localparam logic [2:0] DST_PX = 3'd2;
   localparam logic [2:0] DST_PY = 3'd3;
   localparam logic [2:0] DST_KX = 3'd4;
   localparam logic [2:0] DST_KY = 3'd5;
   localparam logic [2:0] DST_T1 = 3'd6;
   localparam logic [2:0] DST_T2 = 3'd7;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] prey_init;
      logic signed [DATA_W-1:0] predator_init;
      logic signed [DATA_W-1:0] start_time;
   } pps_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prey_out;
      logic signed [DATA_W-1:0] predator_out;
      logic signed [DATA_W-1:0] time_out;
      logic                     last;
   } pps_rsp_type;

   typedef struct packed {
      logic       capture;
      logic [2:0] op;
      logic [3:0] a_sel;
      logic [3:0] b_sel;
      logic [2:0] dst;
      logic       inc_half;
      logic       acc_dbl;
   } pps_cmd_type;

   typedef struct packed {
      logic use_rk4;
   } pps_status_type;

   function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi)
         return 32'sh7FFF_FFFF;
      else if (v < lo)
         return 32'sh8000_0000;
      else
         return v[DATA_W-1:0];
   endfunction

endpackage

@@ src/pps_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: config registers, state, shared multiplier, saturating ALU and
// the result register.
// ----------------------------------------------------------------------------
module pps_dp import pps_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   input  pps_req_type          req_data,
   input  pps_cmd_type          cmd,
   output pps_status_type       status,
   output pps_rsp_type          rsp_data
);

   logic signed [DATA_W-1:0] a11_ff, a12_ff, a21_ff, a22_ff, end_time_ff;
   logic [30:0]              step_size_ff;
   logic                     use_rk4_ff;

   logic signed [DATA_W-1:0] x_ff, y_ff, t_ff, px_ff, py_ff, kx_ff, ky_ff, t1_ff, t2_ff;
   logic signed [34:0]       accx_ff, accy_ff;
   logic signed [63:0]       prod_ff;
   logic [63:0]              recip_ff;
   pps_rsp_type              rsp_ff;

   logic signed [DATA_W-1:0] h_s, half_s, sixth_s, inc_s, finc_s, finx_s, finy_s;
   logic signed [DATA_W-1:0] opa, opb, mul_res, alu_res, res, t_in;
   logic [DATA_W-1:0]        h_p1, h_p3;
   logic signed [63:0]       rnd;
   logic signed [34:0]       kx_w, ky_w;
   logic                     last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a11_ff       <= 32'sd65536;
         a12_ff       <= '0;
         a21_ff       <= '0;
         a22_ff       <= '0;
         step_size_ff <= 31'd655;
         end_time_ff  <= 32'sd655360;
         use_rk4_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PREY_GROWTH:    a11_ff       <= csr_wdata;
            CSR_PREDATION_RATE: a12_ff       <= csr_wdata;
            CSR_PREDATOR_GAIN:  a21_ff       <= csr_wdata;
            CSR_PREDATOR_DEATH: a22_ff       <= csr_wdata;
            CSR_STEP_SIZE:      step_size_ff <= csr_wdata[30:0];
            CSR_END_TIME:       end_time_ff  <= csr_wdata;
            CSR_USE_RK4:        use_rk4_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign status.use_rk4 = use_rk4_ff;

   // step constants; h/6 by reciprocal multiply, exact for 32-bit operands
   assign h_s     = {1'b0, step_size_ff};
   assign h_p1    = {1'b0, step_size_ff} + 32'd1;
   assign h_p3    = {1'b0, step_size_ff} + 32'd3;
   assign half_s  = {1'b0, h_p1[31:1]};
   assign sixth_s = {2'b00, recip_ff[63:34]};

   always_ff @(posedge clock) begin
      recip_ff <= 64'(h_p3) * 64'(32'hAAAA_AAAB);
   end

   assign inc_s  = cmd.inc_half ? half_s : h_s;
   assign finc_s = use_rk4_ff ? sixth_s : h_s;
   assign finx_s = use_rk4_ff ? sat64(64'(accx_ff)) : kx_ff;
   assign finy_s = use_rk4_ff ? sat64(64'(accy_ff)) : ky_ff;

   function automatic logic signed [DATA_W-1:0] pick(input logic [3:0] sel,
      input logic signed [DATA_W-1:0] x, y, px, py, kx, ky, t1, t2,
      a11, a12, a21, a22, inc, finc, finx, finy);
      logic signed [DATA_W-1:0] v;
      case (sel)
         SRC_X:    v = x;
         SRC_Y:    v = y;
         SRC_PX:   v = px;
         SRC_PY:   v = py;
         SRC_KX:   v = kx;
         SRC_KY:   v = ky;
         SRC_T1:   v = t1;
         SRC_T2:   v = t2;
         SRC_A11:  v = a11;
         SRC_A12:  v = a12;
         SRC_A21:  v = a21;
         SRC_A22:  v = a22;
         SRC_INC:  v = inc;
         SRC_FINC: v = finc;
         SRC_FINX: v = finx;
         default:  v = finy;
      endcase
      return v;
   endfunction

   assign opa = pick(cmd.a_sel, x_ff, y_ff, px_ff, py_ff, kx_ff, ky_ff, t1_ff, t2_ff,
                     a11_ff, a12_ff, a21_ff, a22_ff, inc_s, finc_s, finx_s, finy_s);
   assign opb = pick(cmd.b_sel, x_ff, y_ff, px_ff, py_ff, kx_ff, ky_ff, t1_ff, t2_ff,
                     a11_ff, a12_ff, a21_ff, a22_ff, inc_s, finc_s, finx_s, finy_s);

   always_ff @(posedge clock) begin
      prod_ff <= 64'(opa) * 64'(opb);
   end

   // round half up, floor shift, saturate
   assign rnd     = prod_ff + (64'sd1 <<< (FRAC_BITS - 1));
   assign mul_res = sat64(rnd >>> FRAC_BITS);
   assign alu_res = (cmd.op == OP_SUB) ? sat64(64'(opa) - 64'(opb))
                                       : sat64(64'(opa) + 64'(opb));
   assign res     = (cmd.op == OP_WB) ? mul_res : alu_res;

   assign kx_w = cmd.acc_dbl ? (35'(kx_ff) <<< 1) : 35'(kx_ff);
   assign ky_w = cmd.acc_dbl ? (35'(ky_ff) <<< 1) : 35'(ky_ff);

   assign t_in    = sat64(64'(t_ff) + 64'(h_s));
   assign last_in = (t_in >= end_time_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         t_ff <= '0;
      end else if (cmd.capture) begin
         if (!req_data.func) begin
            x_ff <= req_data.prey_init;
            y_ff <= req_data.predator_init;
            t_ff <= req_data.start_time;
         end else begin
            t_ff <= t_in;
         end
      end else if (cmd.op == OP_WB || cmd.op == OP_ADD || cmd.op == OP_SUB) begin
         if (cmd.dst == DST_X) x_ff <= res;
         if (cmd.dst == DST_Y) y_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff   <= x_ff;
         py_ff   <= y_ff;
         accx_ff <= '0;
         accy_ff <= '0;
         if (!req_data.func) begin
            rsp_ff <= '{req_data.prey_init, req_data.predator_init,
                        req_data.start_time, 1'b0};
         end else begin
            rsp_ff <= '{x_ff, y_ff, t_ff, last_in};
         end
      end else if (cmd.op == OP_ACC) begin
         accx_ff <= accx_ff + kx_w;
         accy_ff <= accy_ff + ky_w;
      end else if (cmd.op == OP_WB || cmd.op == OP_ADD || cmd.op == OP_SUB) begin
         case (cmd.dst)
            DST_PX:  px_ff <= res;
            DST_PY:  py_ff <= res;
            DST_KX:  kx_ff <= res;
            DST_KY:  ky_ff <= res;
            DST_T1:  t1_ff <= res;
            DST_T2:  t2_ff <= res;
            default: ;
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ src/pps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ctrl
// Controller: handshakes and the micro-sequence of one integration step.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_func,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  pps_status_type status,
   output pps_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DERIV = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   localparam logic [1:0] K_MUL = 2'd0;
   localparam logic [1:0] K_ADD = 2'd1;
   localparam logic [1:0] K_SUB = 2'd2;
   localparam logic [1:0] K_ACC = 2'd3;

   localparam logic [3:0] UPC_LAST_RK4   = 4'd12;
   localparam logic [3:0] UPC_LAST_EULER = 4'd7;
   localparam logic [3:0] UPC_LAST_FINAL = 4'd3;

   logic [1:0] state_ff, state_in;
   logic [3:0] upc_ff, upc_in;
   logic [1:0] stage_ff, stage_in;
   logic       half_ff, half_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [1:0] kind;
   logic [3:0] a_sel, b_sel;
   logic [2:0] dst;
   logic       accept;
   logic [3:0] upc_last;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // micro-program
   always_comb begin
      kind  = K_MUL;
      a_sel = SRC_X;
      b_sel = SRC_T1;
      dst   = DST_T1;
      if (state_ff == ST_FINAL) begin
         case (upc_ff)
            4'd0:    begin kind = K_MUL; a_sel = SRC_FINC; b_sel = SRC_FINX; dst = DST_T1; end
            4'd1:    begin kind = K_ADD; a_sel = SRC_X;    b_sel = SRC_T1;   dst = DST_X;  end
            4'd2:    begin kind = K_MUL; a_sel = SRC_FINC; b_sel = SRC_FINY; dst = DST_T2; end
            default: begin kind = K_ADD; a_sel = SRC_Y;    b_sel = SRC_T2;   dst = DST_Y;  end
         endcase
      end else begin
         case (upc_ff)
            4'd0:  begin kind = K_MUL; a_sel = SRC_A11; b_sel = SRC_PX;  dst = DST_T1; end
            4'd1:  begin kind = K_MUL; a_sel = SRC_A12; b_sel = SRC_PX;  dst = DST_T2; end
            4'd2:  begin kind = K_MUL; a_sel = SRC_T2;  b_sel = SRC_PY;  dst = DST_T2; end
            4'd3:  begin kind = K_SUB; a_sel = SRC_T1;  b_sel = SRC_T2;  dst = DST_KX; end
            4'd4:  begin kind = K_MUL; a_sel = SRC_A21; b_sel = SRC_PX;  dst = DST_T1; end
            4'd5:  begin kind = K_MUL; a_sel = SRC_T1;  b_sel = SRC_PY;  dst = DST_T1; end
            4'd6:  begin kind = K_MUL; a_sel = SRC_A22; b_sel = SRC_PY;  dst = DST_T2; end
            4'd7:  begin kind = K_SUB; a_sel = SRC_T1;  b_sel = SRC_T2;  dst = DST_KY; end
            4'd8:  begin kind = K_ACC; end
            4'd9:  begin kind = K_MUL; a_sel = SRC_KX;  b_sel = SRC_INC; dst = DST_T1; end
            4'd10: begin kind = K_ADD; a_sel = SRC_X;   b_sel = SRC_T1;  dst = DST_PX; end
            4'd11: begin kind = K_MUL; a_sel = SRC_KY;  b_sel = SRC_INC; dst = DST_T2; end
            default: begin kind = K_ADD; a_sel = SRC_Y; b_sel = SRC_T2;  dst = DST_PY; end
         endcase
      end
   end

   always_comb begin
      cmd.capture  = accept;
      cmd.a_sel    = a_sel;
      cmd.b_sel    = b_sel;
      cmd.dst      = dst;
      cmd.inc_half = !stage_ff[1];
      cmd.acc_dbl  = stage_ff[1] ^ stage_ff[0];
      if (state_ff == ST_IDLE) begin
         cmd.op = OP_NOP;
      end else begin
         case (kind)
            K_MUL:   cmd.op = half_ff ? OP_WB : OP_NOP;
            K_ADD:   cmd.op = OP_ADD;
            K_SUB:   cmd.op = OP_SUB;
            default: cmd.op = OP_ACC;
         endcase
      end
   end

   assign upc_last = status.use_rk4 ? UPC_LAST_RK4 : UPC_LAST_EULER;

   always_comb begin
      state_in     = state_ff;
      upc_in       = upc_ff;
      stage_in     = stage_ff;
      half_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (accept) rsp_valid_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func) begin
               state_in = ST_DERIV;
               upc_in   = '0;
               stage_in = '0;
            end
         end
         ST_DERIV: begin
            if (kind == K_MUL && !half_ff) begin
               half_in = 1'b1;
            end else if (upc_ff == upc_last) begin
               upc_in = '0;
               if (!status.use_rk4 || stage_ff == 2'd3) begin
                  state_in = ST_FINAL;
               end else begin
                  stage_in = stage_ff + 2'd1;
               end
            end else begin
               upc_in = upc_ff + 4'd1;
            end
         end
         ST_FINAL: begin
            if (kind == K_MUL && !half_ff) begin
               half_in = 1'b1;
            end else if (upc_ff == UPC_LAST_FINAL) begin
               state_in = ST_IDLE;
               upc_in   = '0;
            end else begin
               upc_in = upc_ff + 4'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= '0;
         stage_ff     <= '0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         stage_ff     <= stage_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_step_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func) |=> !req_ready)
      else $error("step beat accepted but ready stayed high");

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("response raised without an accepted request");

   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |-> (upc_ff <= UPC_LAST_FINAL))
      else $error("final micro-sequence counter out of range");

   a_idle_no_half: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !half_ff)
      else $error("multiply phase pending while idle");

endmodule

@@ src/predator_prey_ode_stepper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// predator_prey_ode_stepper
// Lotka-Volterra integrator, RK4 or forward Euler, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request beat (valid/ready). func=0 loads prey, predator
//   and time; func=1 reports the current state and time and then advances one
//   step. Every request gives exactly one rsp_* beat (valid/ready); last is set
//   on a step when the time after it is at or past end_time, never on a load.
//   csr_* writes coefficients, step size, end time and mode; write only idle.
// Response and busy period:
//   The response is registered as the request is taken and is valid in the next cycle.
//   A load leaves the block idle. A step keeps the block busy, taking no new
//   request, in both Euler and RK4 mode: every multiply goes through one shared
//   32x32 multiplier plus a round/saturate write-back, one op at a time.
// Reset:
//   Synchronous, active high; state and time clear to zero, config registers
//   take their default values, no response pending.
// Stall:
//   A finished response waits in its register; once the block is idle, the next
//   request can be taken in the same cycle the response beat leaves.
// ----------------------------------------------------------------------------
module predator_prey_ode_stepper import pps_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pps_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pps_rsp_type          rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   pps_cmd_type    cmd;
   pps_status_type status;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pps_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
